@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/bfa_pkg.sv @@
package bfa_pkg;

  localparam int FRAME_W         = 12;
  localparam int FBW             = FRAME_W + 1;   // frame arithmetic with headroom
  localparam int FIELD_FRAME_MAX = 4095;

  localparam int FRAME_COUNT_DEF = 4096;
  localparam int WORD_BITS_DEF   = 32;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_NOOP
  } bfa_status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_SET,
    S_FRD,
    S_FWR,
    S_DONE
  } bfa_state_t;

endpackage

@@ hdl/bfa_if.sv @@
interface bfa_in_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [FRAME_W-1:0] current_frame;
  logic               user_flag;
  logic               write_flag;

  modport source (output valid, output func, output current_frame, output user_flag,
                  output write_flag, input ready);
  modport sink (input valid, input func, input current_frame, input user_flag,
                input write_flag, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  bfa_status_t        status;
  logic [FRAME_W-1:0] frame_index;
  logic               entry_present;
  logic               entry_user;
  logic               entry_write;

  modport source (output valid, output status, output frame_index, output entry_present,
                  output entry_user, output entry_write, input ready);
  modport sink (input valid, input status, input frame_index, input entry_present,
                input entry_user, input entry_write, output ready);
endinterface

@@ hdl/bitmap_frame_allocator_top.sv @@
// First-fit page-frame allocator over a used-frame bitmap held in one single-port-read,
// single-port-write memory of FRAME_COUNT/WORD_BITS words. After reset the bitmap is
// swept to zero, one word per cycle (128 words at the defaults), and no request is taken
// until the sweep ends. One request is worked on at a time. An alloc reads the bitmap one
// word per cycle through the memory read port, at most min(NUM_WORDS, REACH_WORDS) words
// (128 at the defaults, also when the bitmap is full); a free splits the frame
// number into word and bit by shift and mask (WORD_BITS is a power of two) and then does
// a read-modify-write. A new request is taken while the previous result still waits in
// the output register.
module bitmap_frame_allocator_top import bfa_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfa_in_if.sink    in_ch,
  bfa_out_if.source out_ch
);

  localparam int NUM_WORDS   = FRAME_COUNT / WORD_BITS;
  localparam int MEM_DEPTH   = (NUM_WORDS < 1) ? 1 : NUM_WORDS;
  localparam int WIDX        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int WCNT        = $clog2(MEM_DEPTH + 1);
  localparam int REACH_WORDS = (FIELD_FRAME_MAX + WORD_BITS) / WORD_BITS;
  localparam int SCAN_WORDS  = (NUM_WORDS < REACH_WORDS) ? NUM_WORDS : REACH_WORDS;
  localparam int BIW         = $clog2(WORD_BITS);

  // bitmap memory
  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we;
  logic [WIDX-1:0]      mem_wa;
  logic [WIDX-1:0]      mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  bfa_state_t           state_r, state_nxt;
  logic [WCNT-1:0]      clr_w_r, clr_w_nxt;
  logic [WCNT-1:0]      iss_w_r, iss_w_nxt;
  logic [FBW-1:0]       iss_base_r, iss_base_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [WCNT-1:0]      chk_w_r, chk_w_nxt;
  logic [FBW-1:0]       chk_base_r, chk_base_nxt;
  logic [WIDX-1:0]      set_w_r, set_w_nxt;
  logic [WORD_BITS-1:0] wr_word_r, wr_word_nxt;
  logic [FBW-1:0]       frame_r, frame_nxt;
  logic                 user_r, user_nxt;
  logic                 write_r, write_nxt;

  logic [BIW-1:0]       rem_r, rem_nxt;
  logic [FRAME_W-1:0]   quo_r, quo_nxt;

  bfa_status_t          res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic                 res_present_r, res_present_nxt;
  logic                 res_user_r, res_user_nxt;
  logic                 res_write_r, res_write_nxt;

  logic                 out_valid_r, out_valid_nxt;
  bfa_status_t          out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic                 out_present_r, out_present_nxt;
  logic                 out_user_r, out_user_nxt;
  logic                 out_write_r, out_write_nxt;

  logic                 in_ready;
  logic [WORD_BITS-1:0] zero_oh;
  logic [BIW-1:0]       zero_idx;
  logic                 word_full;
  logic                 scan_issue;

  // lowest clear bit of the word under test, one-hot, then encoded
  always_comb begin
    zero_oh   = ~rd_data_r & (rd_data_r + 1'b1);
    word_full = &rd_data_r;
    zero_idx  = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_oh[i]) begin
        zero_idx = zero_idx | BIW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_w_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_w_r       <= iss_w_nxt;
    iss_base_r    <= iss_base_nxt;
    chk_w_r       <= chk_w_nxt;
    chk_base_r    <= chk_base_nxt;
    set_w_r       <= set_w_nxt;
    wr_word_r     <= wr_word_nxt;
    frame_r       <= frame_nxt;
    user_r        <= user_nxt;
    write_r       <= write_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    res_status_r  <= res_status_nxt;
    res_frame_r   <= res_frame_nxt;
    res_present_r <= res_present_nxt;
    res_user_r    <= res_user_nxt;
    res_write_r   <= res_write_nxt;
    out_status_r  <= out_status_nxt;
    out_frame_r   <= out_frame_nxt;
    out_present_r <= out_present_nxt;
    out_user_r    <= out_user_nxt;
    out_write_r   <= out_write_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_w_nxt       = clr_w_r;
    iss_w_nxt       = iss_w_r;
    iss_base_nxt    = iss_base_r;
    chk_v_nxt       = 1'b0;
    chk_w_nxt       = chk_w_r;
    chk_base_nxt    = chk_base_r;
    set_w_nxt       = set_w_r;
    wr_word_nxt     = wr_word_r;
    frame_nxt       = frame_r;
    user_nxt        = user_r;
    write_nxt       = write_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    res_status_nxt  = res_status_r;
    res_frame_nxt   = res_frame_r;
    res_present_nxt = res_present_r;
    res_user_nxt    = res_user_r;
    res_write_nxt   = res_write_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_frame_nxt   = out_frame_r;
    out_present_nxt = out_present_r;
    out_user_nxt    = out_user_r;
    out_write_nxt   = out_write_r;
    in_ready        = 1'b0;
    scan_issue      = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = set_w_r;
    mem_wd          = wr_word_r;
    mem_ra          = WIDX'(quo_r);

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_w_r[WIDX-1:0];
        mem_wd = '0;
        clr_w_nxt = clr_w_r + 1'b1;
        if (clr_w_r == WCNT'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready        = 1'b1;
        user_nxt        = in_ch.user_flag;
        write_nxt       = in_ch.write_flag;
        res_status_nxt  = ST_NOOP;
        res_frame_nxt   = '0;
        res_present_nxt = 1'b0;
        res_user_nxt    = 1'b0;
        res_write_nxt   = 1'b0;
        iss_w_nxt       = '0;
        iss_base_nxt    = '0;
        // word index and bit position of the frame to free
        rem_nxt         = in_ch.current_frame[BIW-1:0];
        quo_nxt         = in_ch.current_frame >> BIW;
        if (in_ch.valid) begin
          if (in_ch.current_frame != '0) begin
            state_nxt = (in_ch.func == FUNC_FREE) ? S_FRD : S_DONE;
          end else begin
            state_nxt = (in_ch.func == FUNC_ALLOC) ? S_SCAN : S_DONE;
          end
        end
      end

      // one word read issued per cycle, checked in the cycle after
      S_SCAN: begin
        scan_issue = (iss_w_r < WCNT'(SCAN_WORDS));
        mem_ra     = iss_w_r[WIDX-1:0];
        chk_v_nxt  = scan_issue;
        chk_w_nxt  = iss_w_r;
        chk_base_nxt = iss_base_r;
        if (scan_issue) begin
          iss_w_nxt    = iss_w_r + 1'b1;
          iss_base_nxt = iss_base_r + FBW'(WORD_BITS);
        end
        if (chk_v_r && !word_full) begin
          chk_v_nxt   = 1'b0;
          frame_nxt   = chk_base_r + FBW'(zero_idx);
          wr_word_nxt = rd_data_r | zero_oh;
          set_w_nxt   = chk_w_r[WIDX-1:0];
          state_nxt   = S_SET;
        end else if (!chk_v_r && !scan_issue) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end
      end

      S_SET: begin
        if (frame_r > FBW'(FIELD_FRAME_MAX)) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we          = 1'b1;
          res_status_nxt  = ST_DONE;
          res_frame_nxt   = frame_r[FRAME_W-1:0];
          res_present_nxt = 1'b1;
          res_user_nxt    = user_r;
          res_write_nxt   = write_r;
        end
        state_nxt = S_DONE;
      end

      S_FRD: begin
        if ({{(32 - FRAME_W){1'b0}}, quo_r} < 32'(NUM_WORDS)) begin
          state_nxt = S_FWR;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FWR: begin
        mem_we         = 1'b1;
        mem_wa         = WIDX'(quo_r);
        mem_wd         = rd_data_r & ~(WORD_BITS'(1) << rem_r);
        res_status_nxt = ST_DONE;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_frame_nxt   = res_frame_r;
          out_present_nxt = res_present_r;
          out_user_nxt    = res_user_r;
          out_write_nxt   = res_write_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.frame_index   = out_frame_r;
  assign out_ch.entry_present = out_present_r;
  assign out_ch.entry_user    = out_user_r;
  assign out_ch.entry_write   = out_write_r;

endmodule

@@ hdl/bfa_checker.sv @@
`include "assert_macros.svh"

module bfa_checker import bfa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bfa_status_t        out_status,
  input logic [FRAME_W-1:0] out_frame_index,
  input logic               out_entry_present,
  input logic               out_entry_user,
  input logic               out_entry_write
);

  // stalled result transaction keeps its status, frame index and present flag
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_frame_index) && $stable(out_entry_present))

  // full or no-op results carry nothing else
  `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_status != ST_DONE, out_frame_index == '0 && !out_entry_present && !out_entry_user && !out_entry_write)

  `ASSERT_IMPL(a_present_done, clk, rst_n, out_valid && out_entry_present, out_status == ST_DONE)

  // a completed free returns an empty entry
  `ASSERT_IMPL(a_free_empty, clk, rst_n, out_valid && out_status == ST_DONE && !out_entry_present, out_frame_index == '0 && !out_entry_user && !out_entry_write)

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_frame_index   (out_ch.frame_index),
  .out_entry_present (out_ch.entry_present),
  .out_entry_user    (out_ch.entry_user),
  .out_entry_write   (out_ch.entry_write)
);
